/* rtl/thpu_pkg.sv */
// Shared constants, types and lookup functions for the turtle heading/position unit.
package thpu_pkg;

  // Fixed-point setup
  localparam int DIST_BITS      = 12;
  localparam int POS_FRAC_BITS  = 16;
  localparam int TRIG_FRAC_BITS = 15;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int AMT_W  = 12;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 9;
  localparam int DIST_W = (DIST_BITS < AMT_W) ? DIST_BITS : AMT_W;

  // Trig words are one bit wider than the fraction so that sin(90) = 1.0 fits
  localparam int TRIG_W = TRIG_FRAC_BITS + 1;
  localparam int IDX_W  = 7;

  // Angle constants, degrees
  localparam int DEG_FULL = 360;
  localparam int DEG_HALF = 180;
  localparam int DEG_QTR  = 90;

  // Rescale from trig fraction to position fraction
  localparam int FRAC_SH = POS_FRAC_BITS - TRIG_FRAC_BITS;
  localparam int LSH     = (FRAC_SH > 0) ? FRAC_SH : 0;
  localparam int RSH     = (FRAC_SH < 0) ? -FRAC_SH : 0;
  localparam int PROD_W  = DIST_W + TRIG_W;
  localparam int STEP_W  = PROD_W + LSH + 1;
  localparam int SUM_W   = ((STEP_W > POS_W) ? STEP_W : POS_W) + 2;

  // amount mod 360 by reciprocal: q = (a * 182) >> 16 is floor or floor-1
  localparam int RECIP_360 = 182;
  localparam int RECIP_W   = 8;
  localparam int RECIP_SH  = 16;
  localparam int MQ_W      = AMT_W + RECIP_W - RECIP_SH;

  typedef enum logic [CMD_W-1:0] {
    CMD_FWD   = 2'd0,
    CMD_RIGHT = 2'd1,
    CMD_LEFT  = 2'd2
  } cmd_t;

  // Signed trig value as sign and magnitude
  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  // Heading update request
  typedef struct packed {
    logic              valid;
    logic              left;
    logic [HEAD_W-1:0] deg;
  } turn_req_t;

  function automatic logic [HEAD_W-1:0] mod360(input logic [AMT_W-1:0] a);
    logic [AMT_W+RECIP_W-1:0] prod;
    logic [MQ_W-1:0]          q;
    logic [AMT_W-1:0]         r;
    prod = a * RECIP_W'(RECIP_360);
    q    = MQ_W'(prod >> RECIP_SH);
    r    = a - AMT_W'(AMT_W'(q) * AMT_W'(DEG_FULL));
    if (r >= AMT_W'(DEG_FULL)) begin
      r = r - AMT_W'(DEG_FULL);
    end
    return HEAD_W'(r);
  endfunction

  // Quarter-wave sine, sin(k deg) * 2^15 rounded, k = 0..90
  function automatic logic [TRIG_W-1:0] sin_rom(input logic [IDX_W-1:0] k);
    logic [TRIG_W-1:0] v;
    case (k)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
      7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
      7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
      7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      7'd90: v = 16'd32768;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/turtle_heading_position_unit.sv */
// Turtle pen unit: takes one command beat per cycle when not stalled and, for
// each forward command, returns one segment beat (start and end point, signed
// Q16.16). A command passes an input register and then, if it is a forward
// move, the result register. Throughput is one command per cycle unless the
// result side stalls, set by the combinational heading and position update
// (table lookup, one 12x16 multiply and a saturating add per axis). Turns and
// the unused command code update state (or nothing) and return no beat; they
// never wait on the result side. A forward command holds in the input
// register only while the result register is full and out_ready is low.
// Heading starts at zero (pointing along +y) and the pen at the origin.
module turtle_heading_position_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [thpu_pkg::CMD_W-1:0]         in_cmd,
  input  logic [thpu_pkg::AMT_W-1:0]         in_amount,
  // segment channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [thpu_pkg::POS_W-1:0]  out_start_x,
  output logic signed [thpu_pkg::POS_W-1:0]  out_start_y,
  output logic signed [thpu_pkg::POS_W-1:0]  out_end_x,
  output logic signed [thpu_pkg::POS_W-1:0]  out_end_y
);

  // ---------------- input register ----------------
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [thpu_pkg::CMD_W-1:0]    s1_cmd_r;
  logic [thpu_pkg::DIST_W-1:0]   s1_dist_r;
  logic [thpu_pkg::HEAD_W-1:0]   s1_deg_r;

  // ---------------- state and result ----------------
  logic [thpu_pkg::POS_W-1:0]    pos_x_r;
  logic [thpu_pkg::POS_W-1:0]    pos_y_r;
  logic [thpu_pkg::POS_W-1:0]    pos_x_nxt;
  logic [thpu_pkg::POS_W-1:0]    pos_y_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [thpu_pkg::POS_W-1:0]    out_start_x_r;
  logic [thpu_pkg::POS_W-1:0]    out_start_y_r;
  logic [thpu_pkg::POS_W-1:0]    out_end_x_r;
  logic [thpu_pkg::POS_W-1:0]    out_end_y_r;

  logic                          in_acc;
  logic                          s1_fwd;
  logic                          s1_adv;
  logic                          fwd_go;
  logic                          out_free;
  logic [thpu_pkg::HEAD_W-1:0]   heading;
  thpu_pkg::turn_req_t           turn_req;
  thpu_pkg::trig_t               trig_sin;
  thpu_pkg::trig_t               trig_cos;

  // Handshake: the input register drains when its command needs no result
  // slot, or the slot is free or being emptied this cycle.
  assign s1_fwd    = (s1_cmd_r == thpu_pkg::CMD_FWD);
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && (!s1_fwd || out_free);
  assign fwd_go    = s1_adv && s1_fwd;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_acc    = in_valid && in_ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = fwd_go || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Turn amount is reduced mod 360 on the way in, keeping the heading
  // update down to one add and one wrap.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_cmd;
      s1_dist_r <= in_amount[thpu_pkg::DIST_W-1:0];
      s1_deg_r  <= thpu_pkg::mod360(in_amount);
    end
  end

  // ---------------- heading ----------------
  assign turn_req.valid = s1_adv && ((s1_cmd_r == thpu_pkg::CMD_RIGHT) ||
                                     (s1_cmd_r == thpu_pkg::CMD_LEFT));
  assign turn_req.left  = (s1_cmd_r == thpu_pkg::CMD_LEFT);
  assign turn_req.deg   = s1_deg_r;

  thpu_turn u_turn (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (turn_req),
    .heading (heading)
  );

  thpu_trig u_trig (
    .heading (heading),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos)
  );

  // ---------------- position: x follows sine, y follows cosine ----------------
  thpu_axis u_axis_x (
    .pos_i  (pos_x_r),
    .dist_i (s1_dist_r),
    .trig_i (trig_sin),
    .pos_o  (pos_x_nxt)
  );

  thpu_axis u_axis_y (
    .pos_i  (pos_y_r),
    .dist_i (s1_dist_r),
    .trig_i (trig_cos),
    .pos_o  (pos_y_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else if (fwd_go) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  // Segment beat payload, loaded with the move it reports
  always_ff @(posedge clk) begin
    if (fwd_go) begin
      out_start_x_r <= pos_x_r;
      out_start_y_r <= pos_y_r;
      out_end_x_r   <= pos_x_nxt;
      out_end_y_r   <= pos_y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_start_x = out_start_x_r;
  assign out_start_y = out_start_y_r;
  assign out_end_x   = out_end_x_r;
  assign out_end_y   = out_end_y_r;

  // ---------------- assertions ----------------
  // Heading always stays inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    heading < thpu_pkg::HEAD_W'(thpu_pkg::DEG_FULL))
    else $error("heading out of range");

  // A pending segment always ends where the pen now sits.
  a_end_is_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_end_x_r == pos_x_r) && (out_end_y_r == pos_y_r))
    else $error("segment end differs from pen position");

  // A forward move reports its start from the old pen position.
  a_start_from_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_go |=> out_valid_r && (out_start_x_r == $past(pos_x_r)) &&
               (out_start_y_r == $past(pos_y_r)))
    else $error("segment start mismatch");

  // Commands other than forward never move the pen.
  a_turn_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_fwd) |=> $stable(pos_x_r) && $stable(pos_y_r))
    else $error("pen moved on a non-forward command");

endmodule

/* rtl/thpu_turn.sv */
// Heading register with modulo-360 turn update.
module thpu_turn (
  input  logic                           clk,
  input  logic                           rst_n,
  input  thpu_pkg::turn_req_t            req,
  output logic [thpu_pkg::HEAD_W-1:0]    heading
);

  logic [thpu_pkg::HEAD_W-1:0] heading_r;
  logic [thpu_pkg::HEAD_W-1:0] heading_nxt;
  logic [thpu_pkg::HEAD_W:0]   sum;

  // sum is below 720 in both directions, so one subtract wraps it
  always_comb begin
    if (req.left) begin
      sum = {1'b0, heading_r} + (thpu_pkg::HEAD_W+1)'(thpu_pkg::DEG_FULL) - {1'b0, req.deg};
    end else begin
      sum = {1'b0, heading_r} + {1'b0, req.deg};
    end
    if (sum >= (thpu_pkg::HEAD_W+1)'(thpu_pkg::DEG_FULL)) begin
      heading_nxt = thpu_pkg::HEAD_W'(sum - (thpu_pkg::HEAD_W+1)'(thpu_pkg::DEG_FULL));
    end else begin
      heading_nxt = thpu_pkg::HEAD_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
    end else if (req.valid) begin
      heading_r <= heading_nxt;
    end
  end

  assign heading = heading_r;

endmodule

/* rtl/thpu_trig.sv */
// Sine and cosine of the heading from the quarter-wave table.
module thpu_trig (
  input  logic [thpu_pkg::HEAD_W-1:0] heading,
  output thpu_pkg::trig_t             sin_o,
  output thpu_pkg::trig_t             cos_o
);

  logic [1:0]                  quad;
  logic [1:0]                  quad_c;
  logic [thpu_pkg::IDX_W-1:0]  rem;
  logic [thpu_pkg::IDX_W-1:0]  idx_s;
  logic [thpu_pkg::IDX_W-1:0]  idx_c;
  logic [thpu_pkg::HEAD_W-1:0] base;

  always_comb begin
    if (heading >= thpu_pkg::HEAD_W'(thpu_pkg::DEG_HALF + thpu_pkg::DEG_QTR)) begin
      quad = 2'd3;
      base = thpu_pkg::HEAD_W'(thpu_pkg::DEG_HALF + thpu_pkg::DEG_QTR);
    end else if (heading >= thpu_pkg::HEAD_W'(thpu_pkg::DEG_HALF)) begin
      quad = 2'd2;
      base = thpu_pkg::HEAD_W'(thpu_pkg::DEG_HALF);
    end else if (heading >= thpu_pkg::HEAD_W'(thpu_pkg::DEG_QTR)) begin
      quad = 2'd1;
      base = thpu_pkg::HEAD_W'(thpu_pkg::DEG_QTR);
    end else begin
      quad = 2'd0;
      base = '0;
    end
    rem    = thpu_pkg::IDX_W'(heading - base);
    // cos(h) = sin(h + 90): next quadrant, same remainder
    quad_c = quad + 2'd1;
    idx_s  = quad[0]   ? thpu_pkg::IDX_W'(thpu_pkg::DEG_QTR) - rem : rem;
    idx_c  = quad_c[0] ? thpu_pkg::IDX_W'(thpu_pkg::DEG_QTR) - rem : rem;
    sin_o.neg = quad[1];
    sin_o.mag = thpu_pkg::sin_rom(idx_s);
    cos_o.neg = quad_c[1];
    cos_o.mag = thpu_pkg::sin_rom(idx_c);
  end

endmodule

/* rtl/thpu_axis.sv */
// One axis of a move: distance times trig, rescaled, added and saturated.
module thpu_axis (
  input  logic [thpu_pkg::POS_W-1:0]  pos_i,
  input  logic [thpu_pkg::DIST_W-1:0] dist_i,
  input  thpu_pkg::trig_t             trig_i,
  output logic [thpu_pkg::POS_W-1:0]  pos_o
);

  localparam logic [thpu_pkg::STEP_W-1:0] RND =
    thpu_pkg::STEP_W'((64'd1 << thpu_pkg::RSH) >> 1);

  logic [thpu_pkg::PROD_W-1:0] prod;
  logic [thpu_pkg::STEP_W-1:0] step;
  logic [thpu_pkg::SUM_W-1:0]  pos_ext;
  logic [thpu_pkg::SUM_W-1:0]  step_ext;
  logic [thpu_pkg::SUM_W-1:0]  sum;
  logic                        ovf;

  always_comb begin
    prod     = thpu_pkg::PROD_W'(dist_i) * thpu_pkg::PROD_W'(trig_i.mag);
    // round-half-away on magnitude, sign applied after
    step     = ((thpu_pkg::STEP_W'(prod) << thpu_pkg::LSH) + RND) >> thpu_pkg::RSH;
    pos_ext  = {{(thpu_pkg::SUM_W-thpu_pkg::POS_W){pos_i[thpu_pkg::POS_W-1]}}, pos_i};
    step_ext = thpu_pkg::SUM_W'(step);
    sum      = trig_i.neg ? pos_ext - step_ext : pos_ext + step_ext;
    // overflow when the bits above the result sign disagree with it
    ovf      = (sum[thpu_pkg::SUM_W-1:thpu_pkg::POS_W-1] != '0) &&
               (sum[thpu_pkg::SUM_W-1:thpu_pkg::POS_W-1] != '1);
    if (ovf) begin
      pos_o = sum[thpu_pkg::SUM_W-1] ? {1'b1, {(thpu_pkg::POS_W-1){1'b0}}}
                                     : {1'b0, {(thpu_pkg::POS_W-1){1'b1}}};
    end else begin
      pos_o = sum[thpu_pkg::POS_W-1:0];
    end
  end

endmodule

/* dv/turtle_heading_position_unit_tb.sv */
// Self-checking testbench for the turtle pen unit: command beats in, segment beats checked.
module turtle_heading_position_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thpu_pkg::*;

  // Code 3 has no member in cmd_t; the unit must drop it without a trace.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SCALE_SH   = POS_FRAC_BITS - TRIG_FRAC_BITS;
  localparam int DIST_MAX   = (1 << AMT_W) - 1;
  localparam int HOLD_LEN   = 80;     // receiver hold-off for the backpressure test
  localparam int MAX_SHOWN  = 10;     // mismatches printed in full

  typedef struct packed {
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
  } segment_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic [AMT_W-1:0]         in_amount = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [POS_W-1:0]  out_start_x;
  logic signed [POS_W-1:0]  out_start_y;
  logic signed [POS_W-1:0]  out_end_x;
  logic signed [POS_W-1:0]  out_end_y;

  turtle_heading_position_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_amount   (in_amount),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_start_x (out_start_x),
    .out_start_y (out_start_y),
    .out_end_x   (out_end_x),
    .out_end_y   (out_end_y)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pen model: heading in degrees, position in Q16.16, quarter-wave sine table.
  // Updated once per accepted command beat; segments it predicts wait in
  // segment_q until the matching output beat shows up.
  // ---------------------------------------------------------------------------
  longint unsigned         sine_tab [0:DEG_QTR];
  int unsigned             heading_deg;
  logic signed [POS_W-1:0] pen_x;
  logic signed [POS_W-1:0] pen_y;
  segment_t                segment_q [$];

  bit idle_en = 1'b1;        // random idling on both sides
  int hold_req = 0;          // cycles of receiver hold-off asked by a test
  int hold_left = 0;
  int errors = 0;

  // Table of sin(k deg), k = 0..90, as an unsigned word with TRIG_FRAC_BITS
  // fraction bits. Built from a Q30 Taylor series so every entry lands on the
  // same rounding as the design's ROM should.
  function automatic void build_sine_table();
    longint unsigned one_deg;
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    int              rs;
    one_deg = 64'h3243F6A8885A308D / 64'd180;
    rs = 30 - TRIG_FRAC_BITS;
    for (int k = 0; k <= DEG_QTR; k++) begin
      x = (longint'(k) * one_deg + (64'd1 << 29)) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      sine_tab[k] = (longint'(acc) + (64'd1 << (rs - 1))) >> rs;
    end
  endfunction

  // Signed move along one axis: move_len * sin(deg), rescaled to the position
  // fraction. Right shifts round half away from zero on the magnitude.
  function automatic longint axis_step(input int unsigned move_len, input int unsigned deg);
    int unsigned     quad;
    int unsigned     rem;
    int              rs;
    longint unsigned prod;
    quad = (deg / DEG_QTR) % 4;
    rem  = deg % DEG_QTR;
    prod = longint'(move_len) * sine_tab[(quad % 2 == 1) ? (DEG_QTR - rem) : rem];
    if (SCALE_SH >= 0) begin
      prod = prod << SCALE_SH;
    end else begin
      rs = -SCALE_SH;
      prod = (prod + (64'd1 << (rs - 1))) >> rs;
    end
    return (quad >= 2) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > longint'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end
    if (v < -longint'(64'h80000000)) begin
      return 32'sh80000000;
    end
    return POS_W'(v);
  endfunction

  // Apply one accepted command to the pen model.
  function automatic void track_command(input logic [CMD_W-1:0] cmd,
                                        input logic [AMT_W-1:0] amt);
    segment_t    seg;
    int unsigned move_len;
    if (cmd == CMD_FWD) begin
      move_len = int'(amt) & ((1 << DIST_BITS) - 1);
      seg.start_x = pen_x;
      seg.start_y = pen_y;
      seg.end_x = clamp_pos(longint'(pen_x) + axis_step(move_len, heading_deg));
      seg.end_y = clamp_pos(longint'(pen_y) +
                            axis_step(move_len, (heading_deg + DEG_QTR) % DEG_FULL));
      pen_x = seg.end_x;
      pen_y = seg.end_y;
      segment_q.push_back(seg);
    end else if (cmd == CMD_RIGHT) begin
      heading_deg = (heading_deg + int'(amt)) % DEG_FULL;
    end else if (cmd == CMD_LEFT) begin
      heading_deg = (heading_deg + DEG_FULL - (int'(amt) % DEG_FULL)) % DEG_FULL;
    end
    // unused code: no state change, no segment
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Called in the time step of a rising edge; returns in the
  // step of the edge that accepted the beat. Valid stays up between
  // back-to-back beats, so it gets a single NBA per step.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [AMT_W-1:0] amt);
    while (idle_en && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_amount <= amt;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    track_command(cmd, amt);
  endtask

  // ---------------------------------------------------------------------------
  // Segment side: checks every beat against the oldest prediction and drives
  // out_ready for the next cycle (random idling or a requested hold-off).
  // ---------------------------------------------------------------------------
  task automatic check_segment();
    segment_t want;
    if (segment_q.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN) begin
        $display("%0t: segment beat with none expected: start (%0d,%0d) end (%0d,%0d)",
                 $realtime, out_start_x, out_start_y, out_end_x, out_end_y);
      end
    end else begin
      want = segment_q.pop_front();
      if (out_start_x !== want.start_x || out_start_y !== want.start_y ||
          out_end_x !== want.end_x || out_end_y !== want.end_y) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("%0t: segment mismatch", $realtime);
          $display("  start_x exp %0d got %0d", want.start_x, out_start_x);
          $display("  start_y exp %0d got %0d", want.start_y, out_start_y);
          $display("  end_x   exp %0d got %0d", want.end_x, out_end_x);
          $display("  end_y   exp %0d got %0d", want.end_y, out_end_y);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_segment();
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99) < 7);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh out of reset: heading 0 points along +y, pen at origin.
  task automatic test_reset_moves();
    send_cmd(CMD_FWD, '0);                 // zero-length segment
    send_cmd(CMD_FWD, AMT_W'(DIST_MAX));   // longest move straight up
  endtask

  // Turn wrap, amounts over a full turn, left by zero, unused code.
  task automatic test_turns();
    send_cmd(CMD_RIGHT, AMT_W'(90));
    send_cmd(CMD_FWD, AMT_W'(100));
    send_cmd(CMD_RIGHT, AMT_W'(DIST_MAX)); // wraps several times
    send_cmd(CMD_FWD, AMT_W'(DIST_MAX));
    send_cmd(CMD_LEFT, AMT_W'(DIST_MAX));  // left amount taken mod 360
    send_cmd(CMD_UNUSED, AMT_W'(DIST_MAX));
    send_cmd(CMD_FWD, AMT_W'(1));
    send_cmd(CMD_LEFT, '0);
    send_cmd(CMD_RIGHT, AMT_W'(1));        // odd degree, off the quadrant edge
    send_cmd(CMD_FWD, AMT_W'(7));
  endtask

  // Drive y into the positive limit, then x into the negative limit; the
  // extra moves check that a clamped coordinate stays clamped.
  task automatic test_saturation();
    send_cmd(CMD_LEFT, AMT_W'(heading_deg));
    repeat (8) send_cmd(CMD_FWD, AMT_W'(DIST_MAX));
    send_cmd(CMD_LEFT, AMT_W'(DEG_QTR));
    repeat (9) send_cmd(CMD_FWD, AMT_W'(DIST_MAX));
  endtask

  // Receiver stalls for a long stretch while forward moves keep coming, so
  // both internal registers fill and in_ready must drop.
  task automatic test_backpressure();
    hold_req = HOLD_LEN;
    repeat (30) send_cmd(CMD_FWD, AMT_W'($urandom_range(DIST_MAX)));
  endtask

  task automatic test_random(input int count);
    int          n;
    int          pick;
    logic [AMT_W-1:0] amt;
    n = 0;
    while (n < count) begin
      // a quiet stretch with no idling on either side
      idle_en = !(n >= count / 3 && n < count / 2);
      pick = $urandom_range(99);
      if (pick < 2) begin
        // straight run at full distance, pushes toward the position limits
        repeat (8) send_cmd(CMD_FWD, AMT_W'(DIST_MAX));
        n += 8;
      end else if (pick < 52) begin
        case ($urandom_range(19))
          0:       amt = '0;
          1, 2:    amt = AMT_W'(DIST_MAX);
          default: amt = AMT_W'($urandom_range(DIST_MAX));
        endcase
        send_cmd(CMD_FWD, amt);
        n++;
      end else if (pick < 96) begin
        // quadrant-aligned turns hit the table ends and sign flips
        if ($urandom_range(3) == 0) begin
          amt = AMT_W'($urandom_range(45) * DEG_QTR);
        end else begin
          amt = AMT_W'($urandom_range(DIST_MAX));
        end
        send_cmd((pick < 74) ? CMD_RIGHT : CMD_LEFT, amt);
        n++;
      end else begin
        send_cmd(CMD_UNUSED, AMT_W'($urandom_range(DIST_MAX)));
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    int guard;
    build_sine_table();
    heading_deg = 0;
    pen_x = '0;
    pen_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_moves();
    test_turns();
    test_saturation();
    test_backpressure();
    test_random(1300);

    in_valid <= 1'b0;
    guard = 0;
    while (segment_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    // pipeline is two deep; let any stray beat surface
    repeat (20) @(posedge clk);
    if (segment_q.size() != 0) begin
      errors++;
      $display("%0d expected segments never arrived", segment_q.size());
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
